// File: hdl/periodic_task_tick_scheduler_macros.svh
// Assertion macros used by the tick scheduler RTL.
`ifndef PERIODIC_TASK_TICK_SCHEDULER_MACROS_SVH
`define PERIODIC_TASK_TICK_SCHEDULER_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define PTTS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("scheduler assertion failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define PTTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("scheduler assertion failed");

`endif

// File: hdl/ptts_pkg.sv
// Types and constants of the periodic task tick scheduler.
package ptts_pkg;

	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 8;
	localparam int SLOT_W      = 8;
	localparam int PERIOD_W    = 16;
	localparam int DELAY_W     = 8;
	localparam int DUE_W       = 6;
	localparam int ENTRY_W     = 2 * PERIOD_W;

	// Operation carried in tuser of an input beat.
	typedef enum logic {
		FUNC_CREATE = 1'b0,
		FUNC_TICK   = 1'b1
	} func_t;

	// Kind of a result beat, carried in tuser of an output beat.
	typedef enum logic {
		KIND_STATUS = 1'b0,
		KIND_DUE    = 1'b1
	} kind_t;

	// Create status codes.
	typedef enum logic [1:0] {
		STAT_OK         = 2'd0,
		STAT_RANGE      = 2'd1,
		STAT_NO_HANDLER = 2'd2,
		STAT_TAKEN      = 2'd3
	} status_t;

	// Control sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RESP,
		ST_WALK,
		ST_FLUSH
	} state_t;

	// One result beat handed to the output register.
	typedef struct packed {
		kind_t               kind;
		status_t             status;
		logic [DUE_W-1:0]    due_slot;
		logic                last;
	} result_t;

endpackage

// File: hdl/periodic_task_tick_scheduler.sv
// Top level of the periodic task tick scheduler.
//
// A create beat is checked and stored in the cycle it is accepted. Its
// status beat is pushed into the output register from the response state
// once that register is free, and is shown on the master side from there. A
// tick beat walks the slot table one slot per cycle, unless a due slot
// stalls the walk while the output waits on the sink, through the single
// read port of the period/countdown RAM. It passes through acceptance, a
// read per slot, the write-back of the last slot, a check that finds the
// read stage empty, and a flush. Waits on the sink can lengthen the walk and
// the flush. Due slots are reported in index order. The last one is held
// back until the walk ends so that it can carry tlast. Used flags live in
// flip-flops cleared by reset, so no clearing pass is needed.
`include "periodic_task_tick_scheduler_macros.svh"

module periodic_task_tick_scheduler import ptts_pkg::*; #(
	parameter int TASK_SLOTS = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// [7:0] slot, [8] has_handler, [24:9] period, [32:25] first_delay, [39:33] zero
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	input  logic [0:0]             s_axis_tuser,   // [0] func
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [1:0] status, [7:2] due_slot
	output logic [0:0]             m_axis_tuser,   // [0] result_kind
	output logic                   m_axis_tlast
);

	localparam int IW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
	localparam int CW = $clog2(TASK_SLOTS + 1);
	localparam logic [SLOT_W-1:0] SLOT_LIMIT = SLOT_W'(TASK_SLOTS);
	localparam logic [CW-1:0]     WALK_END   = CW'(TASK_SLOTS);

	// Input beat fields.
	logic [SLOT_W-1:0]   in_slot;
	logic                in_has_handler;
	logic [PERIOD_W-1:0] in_period;
	logic [DELAY_W-1:0]  in_first_delay;
	func_t               in_func;
	logic                in_accept;

	assign in_slot        = s_axis_tdata[SLOT_W-1:0];
	assign in_has_handler = s_axis_tdata[SLOT_W];
	assign in_period      = s_axis_tdata[SLOT_W+PERIOD_W:SLOT_W+1];
	assign in_first_delay = s_axis_tdata[SLOT_W+PERIOD_W+DELAY_W:SLOT_W+PERIOD_W+1];
	assign in_func        = func_t'(s_axis_tuser[0]);
	assign in_accept      = s_axis_tvalid && s_axis_tready;

	state_t              state_q, state_d;
	logic [TASK_SLOTS-1:0] used_q;
	status_t             status_q;
	logic [CW-1:0]       rd_cnt_q;
	logic                valid_s2;
	logic [IW-1:0]       slot_idx_s2;
	logic                pend_valid_q;
	logic [IW-1:0]       pend_idx_q;

	logic                ram_we;
	logic [IW-1:0]       ram_waddr;
	logic [ENTRY_W-1:0]  ram_wdata;
	logic                rd_issue;
	logic [ENTRY_W-1:0]  ram_rdata;

	logic                out_push;
	logic                out_free;
	result_t             out_beat;

	// Create checks in priority order: range, handler, occupancy.
	logic [IW-1:0] create_idx;
	status_t       create_status;
	logic          create_ok;

	assign create_idx = in_slot[IW-1:0];

	always_comb begin
		if (in_slot >= SLOT_LIMIT) begin
			create_status = STAT_RANGE;
		end else if (!in_has_handler) begin
			create_status = STAT_NO_HANDLER;
		end else if (used_q[create_idx]) begin
			create_status = STAT_TAKEN;
		end else begin
			create_status = STAT_OK;
		end
	end

	assign create_ok = in_accept && (in_func == FUNC_CREATE) && (create_status == STAT_OK);

	// Walk stage two: the RAM data of slot_idx_s2 is present this cycle.
	logic [PERIOD_W-1:0] cur_cd, cur_per, reload_cd, next_cd;
	logic                used_s2, due, stall, walk_we;

	assign cur_cd    = ram_rdata[PERIOD_W-1:0];
	assign cur_per   = ram_rdata[ENTRY_W-1:PERIOD_W];
	assign used_s2   = used_q[slot_idx_s2];
	assign due       = valid_s2 && used_s2 && (cur_cd == '0);
	// A second due slot cannot be taken while the held one has nowhere to go.
	assign stall     = due && pend_valid_q && !out_free;
	assign reload_cd = due ? cur_per : cur_cd;
	assign next_cd   = reload_cd - PERIOD_W'(1);
	assign walk_we   = valid_s2 && used_s2 && !stall;
	// Reads run one slot ahead of the write-back, so the same entry is never
	// read and written in the same cycle.
	assign rd_issue  = (state_q == ST_WALK) && (rd_cnt_q != WALK_END) && !stall;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_accept) begin
					state_d = (in_func == FUNC_TICK) ? ST_WALK : ST_RESP;
				end
			end
			ST_RESP: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_WALK: begin
				if ((rd_cnt_q == WALK_END) && !valid_s2) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (!pend_valid_q || out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer: handshake, result pushes and RAM writes.
	always_comb begin
		s_axis_tready = 1'b0;
		out_push      = 1'b0;
		out_beat      = '{kind: KIND_DUE, status: STAT_OK,
			due_slot: DUE_W'(pend_idx_q), last: 1'b0};
		ram_we        = 1'b0;
		ram_waddr     = slot_idx_s2;
		ram_wdata     = {cur_per, next_cd};
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				ram_we        = create_ok;
				ram_waddr     = create_idx;
				ram_wdata     = {in_period, PERIOD_W'(in_first_delay)};
			end
			ST_RESP: begin
				out_push = out_free;
				out_beat = '{kind: KIND_STATUS, status: status_q,
					due_slot: '0, last: 1'b1};
			end
			ST_WALK: begin
				out_push = due && pend_valid_q && out_free;
				ram_we   = walk_we;
			end
			ST_FLUSH: begin
				out_push      = pend_valid_q && out_free;
				out_beat.last = 1'b1;
			end
			default: begin
				s_axis_tready = 1'b0;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			used_q       <= '0;
			rd_cnt_q     <= '0;
			valid_s2     <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (create_ok) begin
				used_q[create_idx] <= 1'b1;
			end
			if (state_q == ST_IDLE) begin
				rd_cnt_q <= '0;
			end else if (rd_issue) begin
				rd_cnt_q <= rd_cnt_q + CW'(1);
			end
			if (!stall) begin
				valid_s2 <= rd_issue;
			end
			if ((state_q == ST_WALK) && due && !stall) begin
				pend_valid_q <= 1'b1;
			end else if ((state_q == ST_FLUSH) && out_push) begin
				pend_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			status_q <= create_status;
		end
		if (rd_issue) begin
			slot_idx_s2 <= rd_cnt_q[IW-1:0];
		end
		if (due && !stall) begin
			pend_idx_q <= slot_idx_s2;
		end
	end

	// Period and countdown of every slot, {period, countdown}.
	ptts_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TASK_SLOTS)
	) u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (rd_issue),
		.raddr (rd_cnt_q[IW-1:0]),
		.rdata (ram_rdata)
	);

	ptts_out_reg u_out_reg (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (out_push),
		.beat          (out_beat),
		.free          (out_free),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	// A create status is always the only and therefore the last beat.
	`PTTS_ASSERT_IMPL(a_status_last, clk, arst_n, m_axis_tvalid && (m_axis_tuser[0] == KIND_STATUS), m_axis_tlast)
	// A held due slot never survives past the end of a walk.
	`PTTS_ASSERT_IMPL(a_no_pend_idle, clk, arst_n, state_q == ST_IDLE, !pend_valid_q)
	// A stalled stage two keeps its slot and its RAM data.
	`PTTS_ASSERT_NEXT(a_stall_holds, clk, arst_n, stall, valid_s2 && $stable(slot_idx_s2) && $stable(ram_rdata))

endmodule

// File: hdl/ptts_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module ptts_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read; the data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hdl/ptts_out_reg.sv
// Output register that holds one result beat until the sink takes it.
module ptts_out_reg import ptts_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  result_t                beat,
	output logic                   free,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [1:0] status, [7:2] due_slot
	output logic [0:0]             m_axis_tuser,   // [0] result_kind
	output logic                   m_axis_tlast
);

	logic    valid_q;
	result_t beat_q;

	// Valid flag: set by a push, cleared when the sink takes the beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push) begin
			valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			valid_q <= 1'b0;
		end
	end

	// Payload register.
	always_ff @(posedge clk) begin
		if (push) begin
			beat_q <= beat;
		end
	end

	assign free          = !valid_q || m_axis_tready;
	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = {beat_q.due_slot, beat_q.status};
	assign m_axis_tuser  = beat_q.kind;
	assign m_axis_tlast  = beat_q.last;

endmodule
